// ===== rtl/core/abot_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abot_pkg
// Shared types and constants for the alpha blend over tiled pattern block.
// ----------------------------------------------------------------------------
package abot_pkg;

    // Command codes of the input item.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_BLEND = 1'b1;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_W_LOG2    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_H_LOG2    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [12:0] RST_LINE_WIDTH   = 13'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [2:0]  RST_PAT_W_LOG2   = 3'd3;
    localparam logic [2:0]  RST_PAT_H_LOG2   = 3'd3;

    // Pattern store and counter geometry.
    localparam int STORE_AW   = 12;
    localparam int STORE_DEPTH = 4096;
    localparam int TEXEL_W    = 24;
    localparam int COUNT_W    = 12;
    localparam int FRAME_LINES_MAX = 4096;

    typedef struct packed {
        logic        command;
        logic [11:0] pattern_addr;
        logic [7:0]  pattern_red;
        logic [7:0]  pattern_green;
        logic [7:0]  pattern_blue;
        logic [7:0]  fg_red;
        logic [7:0]  fg_green;
        logic [7:0]  fg_blue;
        logic [7:0]  fg_alpha;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       line_end;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic [12:0] line_width;
        logic [12:0] frame_height;
        logic [2:0]  pat_w_log2;
        logic [2:0]  pat_h_log2;
    } t_cfg;

    // Per-pixel information that travels beside the texel read.
    typedef struct packed {
        logic [7:0] fg_red;
        logic [7:0] fg_green;
        logic [7:0] fg_blue;
        logic [7:0] fg_alpha;
        logic       line_end;
        logic       frame_end;
    } t_side;

endpackage

// ===== rtl/core/alpha_blend_over_tiled_pattern.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_blend_over_tiled_pattern
// Composites a stream of RGBA pixels onto a repeating background pattern.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready / i_in_data) carries two kinds
// of command. A load transfer writes one RGB texel into the 4096-entry
// pattern store at pattern_addr and produces no result. A blend transfer
// takes one foreground pixel, reads the background texel selected by the
// current column and row (each masked to the pattern side) and returns the
// blended colour on the output channel (o_out_valid / i_out_ready /
// o_out_data), tagged with line-end and frame-end flags.
// A blend transfer passes three registered steps before its result: the
// pattern store read, the channel products, and the sum into the output
// register. One item is taken every clock cycle while o_in_ready is high;
// a load followed at once by a blend of the same texel sees the new value,
// as the store write lands before the next read.
// When the receiver stalls, the pipeline keeps accepting items until its
// three stages are full, then drops o_in_ready until results drain.
// Reset clears the raster counters, the pipeline and the configuration to
// 640 x 480 with an 8 x 8 pattern; the store itself is not cleared and must
// be loaded before use. Configuration writes are taken at any edge with
// i_cfg_we high and should be made only while the block is idle.
// ----------------------------------------------------------------------------
module alpha_blend_over_tiled_pattern #(
    parameter int MAX_PATTERN_SIDE_LOG2 = 6,
    parameter int MAX_LINE_PIXELS       = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [abot_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [abot_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  abot_pkg::t_in_item                 i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output abot_pkg::t_out_item                o_out_data
);

    abot_pkg::t_cfg  r_cfg;
    abot_pkg::t_side side;
    logic            in_xfer, load_xfer, blend_xfer;
    logic            blend_ready;
    logic [abot_pkg::STORE_AW-1:0] raddr;
    logic [abot_pkg::TEXEL_W-1:0]  bg;
    logic            line_end, frame_end;

    // Configuration registers: written directly, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_width   <= abot_pkg::RST_LINE_WIDTH;
            r_cfg.frame_height <= abot_pkg::RST_FRAME_HEIGHT;
            r_cfg.pat_w_log2   <= abot_pkg::RST_PAT_W_LOG2;
            r_cfg.pat_h_log2   <= abot_pkg::RST_PAT_H_LOG2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                abot_pkg::CFG_LINE_WIDTH: begin
                    r_cfg.line_width <= i_cfg_data;
                end
                abot_pkg::CFG_FRAME_HEIGHT: begin
                    r_cfg.frame_height <= i_cfg_data;
                end
                abot_pkg::CFG_PAT_W_LOG2: begin
                    r_cfg.pat_w_log2 <= i_cfg_data[2:0];
                end
                abot_pkg::CFG_PAT_H_LOG2: begin
                    r_cfg.pat_h_log2 <= i_cfg_data[2:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Both commands are taken only when the first pipeline stage can move,
    // so that the order of loads and blends is kept at the store.
    assign o_in_ready = blend_ready;
    assign in_xfer    = i_in_valid && blend_ready;
    assign load_xfer  = in_xfer && (i_in_data.command == abot_pkg::CMD_LOAD);
    assign blend_xfer = in_xfer && (i_in_data.command == abot_pkg::CMD_BLEND);

    abot_seq #(
        .MAX_PATTERN_SIDE_LOG2 (MAX_PATTERN_SIDE_LOG2),
        .MAX_LINE_PIXELS       (MAX_LINE_PIXELS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_step      (blend_xfer),
        .o_raddr     (raddr),
        .o_line_end  (line_end),
        .o_frame_end (frame_end)
    );

    // The pattern store: written by loads, read once per blend. Its read data
    // is registered and holds until the next blend read.
    abot_ram #(
        .WIDTH (abot_pkg::TEXEL_W),
        .DEPTH (abot_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (load_xfer),
        .i_waddr (i_in_data.pattern_addr),
        .i_wdata ({i_in_data.pattern_red, i_in_data.pattern_green,
                   i_in_data.pattern_blue}),
        .i_re    (blend_xfer),
        .i_raddr (raddr),
        .o_rdata (bg)
    );

    always_comb begin
        side.fg_red    = i_in_data.fg_red;
        side.fg_green  = i_in_data.fg_green;
        side.fg_blue   = i_in_data.fg_blue;
        side.fg_alpha  = i_in_data.fg_alpha;
        side.line_end  = line_end;
        side.frame_end = frame_end;
    end

    abot_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (blend_xfer),
        .i_side      (side),
        .i_bg        (bg),
        .o_ready     (blend_ready),
        .o_valid     (o_out_valid),
        .o_item      (o_out_data),
        .i_out_ready (i_out_ready)
    );

endmodule

// ===== rtl/core/abot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abot_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module abot_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/abot_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abot_seq
// Raster position counters, end-of-line and end-of-frame flags, and the
// pattern store address of the current pixel.
// ----------------------------------------------------------------------------
module abot_seq #(
    parameter int MAX_PATTERN_SIDE_LOG2 = 6,
    parameter int MAX_LINE_PIXELS       = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  abot_pkg::t_cfg                 i_cfg,
    input  logic                           i_step,
    output logic [abot_pkg::STORE_AW-1:0]  o_raddr,
    output logic                           o_line_end,
    output logic                           o_frame_end
);

    localparam int MLW = $clog2(MAX_LINE_PIXELS + 1);
    localparam int LCW = (MLW > 13) ? MLW : 13;
    localparam int SLR = $clog2(MAX_PATTERN_SIDE_LOG2 + 1);
    localparam int SLW = (SLR > 3) ? SLR : 3;
    localparam int AXW = abot_pkg::STORE_AW + (1 << SLW);
    localparam int CW  = abot_pkg::COUNT_W;

    logic [CW-1:0]  r_col, n_col;
    logic [CW-1:0]  r_row, n_row;
    logic [LCW-1:0] lw, w_last;
    logic [12:0]    fh, h_last;
    logic [SLW-1:0] wl, hl;
    logic [CW-1:0]  mask_x, mask_y;
    logic [AXW-1:0] addr_x;
    logic           lend, fend;

    // Clamp the geometry registers into their legal ranges.
    always_comb begin
        lw = LCW'(i_cfg.line_width);
        if (lw == '0) begin
            lw = LCW'(1);
        end else if (lw > LCW'(MAX_LINE_PIXELS)) begin
            lw = LCW'(MAX_LINE_PIXELS);
        end
        w_last = lw - LCW'(1);

        fh = i_cfg.frame_height;
        if (fh == '0) begin
            fh = 13'd1;
        end else if (fh > 13'(abot_pkg::FRAME_LINES_MAX)) begin
            fh = 13'(abot_pkg::FRAME_LINES_MAX);
        end
        h_last = fh - 13'd1;

        wl = SLW'(i_cfg.pat_w_log2);
        if (wl > SLW'(MAX_PATTERN_SIDE_LOG2)) begin
            wl = SLW'(MAX_PATTERN_SIDE_LOG2);
        end
        hl = SLW'(i_cfg.pat_h_log2);
        if (hl > SLW'(MAX_PATTERN_SIDE_LOG2)) begin
            hl = SLW'(MAX_PATTERN_SIDE_LOG2);
        end
    end

    assign mask_x = (CW'(1) << wl) - CW'(1);
    assign mask_y = (CW'(1) << hl) - CW'(1);
    assign addr_x = (AXW'(r_row & mask_y) << wl) | AXW'(r_col & mask_x);
    assign o_raddr = addr_x[abot_pkg::STORE_AW-1:0];

    // A counter at or past the last position counts as last.
    assign lend = LCW'(r_col) >= w_last;
    assign fend = lend && ({1'b0, r_row} >= h_last);
    assign o_line_end  = lend;
    assign o_frame_end = fend;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (lend) begin
                n_col = '0;
                n_row = fend ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    a_wrap_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && lend |=> r_col == '0)
        else $error("column counter did not wrap after a line end");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_col) && $stable(r_row))
        else $error("raster counters moved without a blend transfer");

endmodule

// ===== rtl/core/abot_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abot_blend
// Three-stage blend pipeline: texel capture, channel products, sum and
// output register, with per-stage hand-off so bubbles close up.
// ----------------------------------------------------------------------------
module abot_blend (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  abot_pkg::t_side                i_side,
    input  logic [abot_pkg::TEXEL_W-1:0]   i_bg,
    output logic                           o_ready,
    output logic                           o_valid,
    output abot_pkg::t_out_item            o_item,
    input  logic                           i_out_ready
);

    logic en1, en2, en3;
    logic r_v1, r_v2, r_v3;
    abot_pkg::t_side     r_s1;
    logic [16:0]         r_pf_r, r_pf_g, r_pf_b;
    logic [16:0]         r_pb_r, r_pb_g, r_pb_b;
    logic                r_le2, r_fe2;
    abot_pkg::t_out_item r_out;
    logic [8:0]          a_fg, a_bg;
    logic [16:0]         sum_r, sum_g, sum_b;

    assign en3 = !r_v3 || i_out_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;

    // Weights: (a + 1) for the foreground, (256 - a) for the background.
    assign a_fg = {1'b0, r_s1.fg_alpha} + 9'd1;
    assign a_bg = 9'd256 - {1'b0, r_s1.fg_alpha};

    assign sum_r = r_pf_r + r_pb_r;
    assign sum_g = r_pf_g + r_pb_g;
    assign sum_b = r_pf_b + r_pb_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1 <= i_side;
        end
        if (en2) begin
            r_pf_r <= 17'(a_fg) * 17'(r_s1.fg_red);
            r_pf_g <= 17'(a_fg) * 17'(r_s1.fg_green);
            r_pf_b <= 17'(a_fg) * 17'(r_s1.fg_blue);
            r_pb_r <= 17'(a_bg) * 17'(i_bg[23:16]);
            r_pb_g <= 17'(a_bg) * 17'(i_bg[15:8]);
            r_pb_b <= 17'(a_bg) * 17'(i_bg[7:0]);
            r_le2  <= r_s1.line_end;
            r_fe2  <= r_s1.frame_end;
        end
        if (en3) begin
            r_out.out_red   <= sum_r[15:8];
            r_out.out_green <= sum_g[15:8];
            r_out.out_blue  <= sum_b[15:8];
            r_out.line_end  <= r_le2;
            r_out.frame_end <= r_fe2;
        end
    end

    assign o_valid = r_v3;
    assign o_item  = r_out;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en1 |-> r_v1 && r_v2 && r_v3)
        else $error("input stalled while the pipeline has a free stage");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && i_out_ready && !r_v2 |=> !r_v3)
        else $error("output register kept a result after its transfer");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alpha blend over tiled pattern block.
// A queue of pending transfers, filled phase by phase, feeds a clocked driver.
// A clocked monitor compares every result with a prediction made when the
// matching pixel was accepted. Geometry is changed only while the block is
// idle. Both channels idle at random, and the receiver sometimes holds off
// for a long stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module tb;

    localparam int LINE_PIXELS_MAX = 4096;
    localparam int SIDE_LOG2_MAX   = 6;
    localparam int ITEM_TARGET     = 1850;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                            i_clk     = 1'b0;
    logic                            i_rst_n   = 1'b0;
    logic                            cfg_we    = 1'b0;
    logic [abot_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [abot_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                            in_valid  = 1'b0;
    abot_pkg::t_in_item              in_data   = '0;
    logic                            out_ready = 1'b0;
    logic                            in_ready;
    logic                            out_valid;
    abot_pkg::t_out_item             out_data;

    // Transfers waiting to be offered, and composited pixels still owed.
    abot_pkg::t_in_item  items_to_send [$];
    abot_pkg::t_out_item composited_due [$];

    // Shadow of the geometry registers, shared by stimulus and prediction.
    logic [12:0] reg_line_width   = abot_pkg::RST_LINE_WIDTH;
    logic [12:0] reg_frame_height = abot_pkg::RST_FRAME_HEIGHT;
    logic [2:0]  reg_pat_w_log2   = abot_pkg::RST_PAT_W_LOG2;
    logic [2:0]  reg_pat_h_log2   = abot_pkg::RST_PAT_H_LOG2;

    // Predicted state: the pattern store and the raster position of the block.
    logic [23:0] background_texels [0:abot_pkg::STORE_DEPTH-1];
    logic [11:0] pred_col = '0;
    logic [11:0] pred_row = '0;

    // Stimulus state: which texels have been loaded, and where the raster
    // will be when the next queued pixel reaches the block.
    bit          texel_loaded [0:abot_pkg::STORE_DEPTH-1];
    logic [11:0] gen_col = '0;
    logic [11:0] gen_row = '0;

    // Pacing. The driver and monitor draw their idle cycles up to these
    // limits; a long hold-off is requested through hold_cycles.
    int gap_max     = 19;
    int stall_max   = 19;
    int hold_cycles = 0;
    int send_gap    = 0;
    int recv_gap    = 0;

    int                  fail_count   = 0;
    int                  queued_count = 0;
    abot_pkg::t_out_item due;

    alpha_blend_over_tiled_pattern #(
        .MAX_PATTERN_SIDE_LOG2 (SIDE_LOG2_MAX),
        .MAX_LINE_PIXELS       (LINE_PIXELS_MAX)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Works out which texel the pixel at (col, row) reads, whether it closes
    // its line and frame, and where the raster moves next. Zero or oversized
    // geometry is clamped, and a position at or beyond the last one after a
    // geometry change counts as last and wraps.
    function automatic void raster_position(input logic [11:0] col, row,
                                            output logic [11:0] texel,
                                            output logic lend, fend,
                                            output logic [11:0] col_next, row_next);
        int w, h, wl, hl, px, py;
        w  = (reg_line_width == 0) ? 1 :
             (reg_line_width > LINE_PIXELS_MAX) ? LINE_PIXELS_MAX : int'(reg_line_width);
        h  = (reg_frame_height == 0) ? 1 :
             (reg_frame_height > abot_pkg::FRAME_LINES_MAX) ?
             abot_pkg::FRAME_LINES_MAX : int'(reg_frame_height);
        wl = (reg_pat_w_log2 > SIDE_LOG2_MAX) ? SIDE_LOG2_MAX : int'(reg_pat_w_log2);
        hl = (reg_pat_h_log2 > SIDE_LOG2_MAX) ? SIDE_LOG2_MAX : int'(reg_pat_h_log2);
        px = int'(col) & ((1 << wl) - 1);
        py = int'(row) & ((1 << hl) - 1);
        texel    = 12'((py << wl) | px);
        lend     = int'(col) >= w - 1;
        fend     = lend && (int'(row) >= h - 1);
        col_next = lend ? 12'd0 : col + 12'd1;
        row_next = !lend ? row : (fend ? 12'd0 : row + 12'd1);
    endfunction

    // One colour channel of the over operation; the result never exceeds 255.
    function automatic logic [7:0] mix_channel(input logic [7:0] fg, bg, alpha);
        int acc;
        acc = (int'(alpha) + 1) * int'(fg) + (256 - int'(alpha)) * int'(bg);
        return 8'(acc >> 8);
    endfunction

    // Prediction for one accepted transfer. A load only updates the store;
    // a blend composites over the texel under the current raster position.
    task automatic predict_composite(input abot_pkg::t_in_item it);
        logic [11:0]         texel;
        logic [23:0]         bg;
        abot_pkg::t_out_item px;
        if (it.command == abot_pkg::CMD_LOAD) begin
            background_texels[it.pattern_addr] =
                {it.pattern_red, it.pattern_green, it.pattern_blue};
        end else begin
            raster_position(pred_col, pred_row, texel, px.line_end, px.frame_end,
                            pred_col, pred_row);
            bg = background_texels[texel];
            px.out_red   = mix_channel(it.fg_red,   bg[23:16], it.fg_alpha);
            px.out_green = mix_channel(it.fg_green, bg[15:8],  it.fg_alpha);
            px.out_blue  = mix_channel(it.fg_blue,  bg[7:0],   it.fg_alpha);
            composited_due.push_back(px);
        end
    endtask

    // A transfer with every field random; the callers then fix the fields
    // that matter, leaving the unused ones to toggle freely.
    function automatic abot_pkg::t_in_item random_item();
        logic [95:0] bits;
        bits = {$urandom, $urandom, $urandom};
        return bits[$bits(abot_pkg::t_in_item)-1:0];
    endfunction

    task automatic queue_texel(input logic [11:0] addr, input logic [7:0] r, g, b);
        abot_pkg::t_in_item it;
        it               = random_item();
        it.command       = abot_pkg::CMD_LOAD;
        it.pattern_addr  = addr;
        it.pattern_red   = r;
        it.pattern_green = g;
        it.pattern_blue  = b;
        texel_loaded[addr] = 1'b1;
        items_to_send.push_back(it);
        queued_count++;
    endtask

    // Queues one foreground pixel. The store is undefined until written, so
    // if the texel under this pixel has never been loaded a load goes first.
    task automatic queue_pixel(input logic [7:0] r, g, b, alpha);
        abot_pkg::t_in_item it;
        logic [11:0]        texel;
        logic               le, fe;
        raster_position(gen_col, gen_row, texel, le, fe, gen_col, gen_row);
        if (!texel_loaded[texel])
            queue_texel(texel, 8'($urandom), 8'($urandom), 8'($urandom));
        it          = random_item();
        it.command  = abot_pkg::CMD_BLEND;
        it.fg_red   = r;
        it.fg_green = g;
        it.fg_blue  = b;
        it.fg_alpha = alpha;
        items_to_send.push_back(it);
        queued_count++;
    endtask

    task automatic write_reg(input logic [abot_pkg::CFG_IDX_W-1:0] idx,
                             input logic [abot_pkg::CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            abot_pkg::CFG_LINE_WIDTH:   reg_line_width   = value;
            abot_pkg::CFG_FRAME_HEIGHT: reg_frame_height = value;
            abot_pkg::CFG_PAT_W_LOG2:   reg_pat_w_log2   = value[2:0];
            abot_pkg::CFG_PAT_H_LOG2:   reg_pat_h_log2   = value[2:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_geometry(input logic [12:0] width, height, w_log2, h_log2);
        write_reg(abot_pkg::CFG_LINE_WIDTH,   width);
        write_reg(abot_pkg::CFG_FRAME_HEIGHT, height);
        write_reg(abot_pkg::CFG_PAT_W_LOG2,   w_log2);
        write_reg(abot_pkg::CFG_PAT_H_LOG2,   h_log2);
    endtask

    // Lets the block go quiet: nothing left to send and no pixel still owed.
    // Loads give no result, so a few more cycles cover one still in flight.
    task automatic wait_drained();
        while (items_to_send.size() != 0 || in_valid || composited_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Line widths and frame heights: the clamped extremes now and then,
    // mostly small so that line and frame ends come often.
    function automatic logic [12:0] pick_extent(input int short_max);
        case ($urandom_range(0, 7))
            0:       return 13'd0;
            1:       return 13'd1;
            2:       return 13'd4096;
            3:       return 13'($urandom_range(4097, 8191));
            default: return 13'($urandom_range(2, short_max));
        endcase
    endfunction

    function automatic logic [7:0] pick_alpha();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Driver: offers the oldest pending transfer and keeps it steady until it
    // is taken. After each transfer it idles for a drawn number of cycles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && in_ready) begin
                predict_composite(in_data);
                send_gap = $urandom_range(0, gap_max);
            end
            if (!in_valid || in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (items_to_send.size() > 0) begin
                    in_data  <= items_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest owed pixel,
    // then stalls for a drawn number of cycles. A requested long hold-off
    // takes precedence and is counted down here.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (composited_due.size() == 0) begin
                    $error("result transfer with no pixel outstanding: %p", out_data);
                    fail_count++;
                end else begin
                    due = composited_due.pop_front();
                    if (out_data.out_red !== due.out_red) begin
                        $error("out_red: expected %0d, got %0d", due.out_red, out_data.out_red);
                        fail_count++;
                    end
                    if (out_data.out_green !== due.out_green) begin
                        $error("out_green: expected %0d, got %0d",
                               due.out_green, out_data.out_green);
                        fail_count++;
                    end
                    if (out_data.out_blue !== due.out_blue) begin
                        $error("out_blue: expected %0d, got %0d",
                               due.out_blue, out_data.out_blue);
                        fail_count++;
                    end
                    if (out_data.line_end !== due.line_end) begin
                        $error("line_end: expected %0d, got %0d",
                               due.line_end, out_data.line_end);
                        fail_count++;
                    end
                    if (out_data.frame_end !== due.frame_end) begin
                        $error("frame_end: expected %0d, got %0d",
                               due.frame_end, out_data.frame_end);
                        fail_count++;
                    end
                end
                recv_gap = $urandom_range(0, stall_max);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Stimulus and sequencing. Coordination happens on the falling edge so
    // that nothing here races the clocked driver and monitor.
    initial begin
        int phase;
        int count;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset geometry: field extremes, fully opaque and fully transparent
        // pixels, and a blend straight after the load of the texel it reads.
        queue_texel(12'hFFF, 8'hFF, 8'hFF, 8'hFF);
        queue_texel(12'h000, 8'h00, 8'h00, 8'h00);
        queue_texel(12'h001, 8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        queue_texel(12'h002, 8'h80, 8'h40, 8'h21);
        queue_pixel(8'hFF, 8'h00, 8'h7F, 8'h80);
        queue_pixel(8'h00, 8'hFF, 8'h00, 8'h01);
        wait_drained();

        // Zero width and height, changed in the middle of a line, so the
        // raster position lies beyond the new last one; pattern sides too
        // large and clamped to the maximum.
        set_geometry(13'd0, 13'd0, 13'd7, 13'd7);
        repeat (3) queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
        wait_drained();

        // Oversized width and height with a single-texel pattern.
        set_geometry(13'h1FFF, 13'h1FFF, 13'd0, 13'd0);
        repeat (3) queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
        wait_drained();

        // A tiny frame so that line and frame ends both come round.
        set_geometry(13'd3, 13'd2, 13'd1, 13'd1);
        repeat (7) queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
        wait_drained();

        // Random phases. Each picks a geometry (the raster carries over, so
        // mid-frame changes arise by themselves) and a pacing, then sends a
        // run of mostly pixels with some texel loads at random addresses.
        queued_count = 0;
        phase = 0;
        while (queued_count < ITEM_TARGET) begin
            set_geometry(pick_extent(24), pick_extent(6),
                         {10'($urandom), 3'($urandom_range(0, 7))},
                         {10'($urandom), 3'($urandom_range(0, 7))});
            case ($urandom_range(0, 3))
                0: begin gap_max = 0;  stall_max = 0;  end
                1: begin gap_max = 19; stall_max = 0;  end
                2: begin gap_max = 0;  stall_max = 19; end
                default: begin gap_max = 19; stall_max = 19; end
            endcase
            // Every fifth phase the receiver holds off at the start while the
            // sender keeps offering, so the pipeline fills and stalls.
            if (phase % 5 == 1) begin
                gap_max     = 0;
                hold_cycles = 150;
            end
            count = $urandom_range(80, 200);
            repeat (count) begin
                if ($urandom_range(0, 9) == 0)
                    queue_texel(12'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                else
                    queue_pixel(8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
            end
            // The sender pauses here until every owed pixel has come back.
            wait_drained();
            phase++;
        end

        if (fail_count == 0 && composited_due.size() == 0) begin
            $display("alpha_blend_over_tiled_pattern verification clean");
        end else begin
            $display("alpha_blend_over_tiled_pattern verification failed");
        end
        $finish;
    end

    // Watchdog, several times the slowest correct run.
    initial begin
        #10ms;
        $display("alpha_blend_over_tiled_pattern verification failed");
        $finish;
    end

endmodule
